// ===== hw/rtl/text_console_cursor_scroll_assert.svh =====
// Assertion macros for the text console.
// Uses clk_i and rst_ni of the module that includes it. No other dependencies.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TCCS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TCCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tccs_pkg.sv =====
// Shared types and constants of the text console.
// No dependencies; every other RTL module file uses it by scoped names.
package tccs_pkg;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
  localparam int ADDR_W      = $clog2(CELL_COUNT);
  localparam int COL_W       = 7;
  localparam int ROW_W       = 5;
  localparam int CELL_W      = 16;

  localparam logic [7:0] CH_NEWLINE  = 8'd10;
  localparam logic [7:0] CH_RETURN   = 8'd13;
  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_BLANK    = 8'h20;
  localparam logic [7:0] RESET_COLOR = 8'h07;
  localparam int         TAB_STEP    = 8;

  typedef enum logic [1:0] {
    ACT_PUT_CHAR  = 2'd0,
    ACT_PUT_ENTRY = 2'd1,
    ACT_READ_CELL = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    action_e          action;
    logic [7:0]       char_code;
    logic [7:0]       entry_color;
    logic [COL_W-1:0] pos_x;
    logic [ROW_W-1:0] pos_y;
  } item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              scrolled;
    logic              bad_position;
  } result_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } cursor_t;

  typedef struct packed {
    cursor_t cur;
    logic    write;
    logic    scroll;
  } cur_res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== hw/rtl/tccs_cell_ram.sv =====
// Cell store of the text console: one write port, one registered read port.
// Depends on tccs_pkg.
module tccs_cell_ram (
  input  logic                               clk_i,
  input  tccs_pkg::mem_req_t                 req_i,
  output logic [tccs_pkg::CELL_W-1:0]        rdata_o
);

  logic [tccs_pkg::CELL_W-1:0] mem_q [tccs_pkg::CELL_COUNT];
  logic [tccs_pkg::CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/tccs_cursor.sv =====
// Cursor advance for one put_char request: newline, return, tab and wrap.
// Depends on tccs_pkg.
module tccs_cursor (
  input  tccs_pkg::cursor_t  cur_i,
  input  logic [7:0]         char_i,
  output tccs_pkg::cur_res_t res_o
);

  logic [tccs_pkg::ROW_W:0] row_inc;
  logic [tccs_pkg::COL_W:0] col_inc;
  logic [tccs_pkg::COL_W:0] col_tab;
  logic                     line_wrap;
  logic [tccs_pkg::ROW_W-1:0] row_next;
  logic                     row_scroll;

  assign row_inc = {1'b0, cur_i.row} + (tccs_pkg::ROW_W+1)'(1);
  assign col_inc = {1'b0, cur_i.col} + (tccs_pkg::COL_W+1)'(1);
  assign col_tab = ({1'b0, cur_i.col} + (tccs_pkg::COL_W+1)'(tccs_pkg::TAB_STEP))
                   & ~(tccs_pkg::COL_W+1)'(tccs_pkg::TAB_STEP - 1);

  always_comb begin
    row_scroll = (int'(row_inc) >= tccs_pkg::SCREEN_ROWS);
    row_next   = row_scroll ? tccs_pkg::ROW_W'(tccs_pkg::SCREEN_ROWS - 1)
                            : row_inc[tccs_pkg::ROW_W-1:0];
  end

  always_comb begin
    res_o      = '0;
    res_o.cur  = cur_i;
    line_wrap  = 1'b0;
    priority if (char_i == tccs_pkg::CH_NEWLINE) begin
      line_wrap = 1'b1;
    end else if (char_i == tccs_pkg::CH_RETURN) begin
      res_o.cur.col = '0;
    end else if (char_i == tccs_pkg::CH_TAB) begin
      if (int'(col_tab) >= tccs_pkg::SCREEN_COLS) begin
        line_wrap = 1'b1;
      end else begin
        res_o.cur.col = col_tab[tccs_pkg::COL_W-1:0];
      end
    end else begin
      res_o.write = 1'b1;
      if (int'(col_inc) >= tccs_pkg::SCREEN_COLS) begin
        line_wrap = 1'b1;
      end else begin
        res_o.cur.col = col_inc[tccs_pkg::COL_W-1:0];
      end
    end
    if (line_wrap) begin
      res_o.cur.col = '0;
      res_o.cur.row = row_next;
      res_o.scroll  = row_scroll;
    end
  end

endmodule

// ===== hw/rtl/tccs_ctrl.sv =====
// Sequencer of the text console: clearing pass, request decode, scroll copy and fill.
// Depends on tccs_pkg, tccs_cursor and the assertion header.
`include "text_console_cursor_scroll_assert.svh"

module tccs_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           item_valid_i,
  output logic                           item_ready_o,
  input  tccs_pkg::item_t                item_i,
  input  logic [7:0]                     color_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output tccs_pkg::result_t              res_o,
  output tccs_pkg::mem_req_t             mem_req_o,
  input  logic [tccs_pkg::CELL_W-1:0]    mem_rdata_i
);

  localparam logic [tccs_pkg::ADDR_W-1:0] LAST_ADDR =
    tccs_pkg::ADDR_W'(tccs_pkg::CELL_COUNT - 1);
  localparam logic [tccs_pkg::ADDR_W-1:0] LAST_COPY =
    tccs_pkg::ADDR_W'(tccs_pkg::CELL_COUNT - tccs_pkg::SCREEN_COLS - 1);
  localparam logic [tccs_pkg::ADDR_W-1:0] ROW_STRIDE =
    tccs_pkg::ADDR_W'(tccs_pkg::SCREEN_COLS);

  tccs_pkg::ctrl_state_e         state_q, state_d;
  logic [tccs_pkg::ADDR_W-1:0]   ptr_q, ptr_d;
  logic [tccs_pkg::ROW_W-1:0]    row_q, row_d;
  logic [tccs_pkg::COL_W-1:0]    col_q, col_d;
  logic                          wr_pend_q, wr_pend_d;
  logic                          wr_blank_q, wr_blank_d;
  logic [tccs_pkg::ADDR_W-1:0]   wr_addr_q, wr_addr_d;
  logic [tccs_pkg::CELL_W-1:0]   res_data_q, res_data_d;
  logic                          res_scr_q, res_scr_d;
  logic                          res_bad_q, res_bad_d;

  tccs_pkg::cursor_t             cur;
  tccs_pkg::cur_res_t            cur_res;
  logic [tccs_pkg::ADDR_W-1:0]   ptr_inc;
  logic [tccs_pkg::ADDR_W-1:0]   cur_index;
  logic [tccs_pkg::ADDR_W-1:0]   pos_index;
  logic                          pos_on_screen;

  assign cur.row = row_q;
  assign cur.col = col_q;

  tccs_cursor u_cursor (
    .cur_i  (cur),
    .char_i (item_i.char_code),
    .res_o  (cur_res)
  );

  assign ptr_inc   = ptr_q + tccs_pkg::ADDR_W'(1);
  assign cur_index = tccs_pkg::ADDR_W'(row_q) * ROW_STRIDE + tccs_pkg::ADDR_W'(col_q);
  assign pos_index = tccs_pkg::ADDR_W'(item_i.pos_y) * ROW_STRIDE
                   + tccs_pkg::ADDR_W'(item_i.pos_x);
  assign pos_on_screen = (int'(item_i.pos_x) < tccs_pkg::SCREEN_COLS)
                      && (int'(item_i.pos_y) < tccs_pkg::SCREEN_ROWS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tccs_pkg::ST_CLEAR;
      ptr_q     <= '0;
      row_q     <= '0;
      col_q     <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      row_q     <= row_d;
      col_q     <= col_d;
      wr_pend_q <= wr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_blank_q <= wr_blank_d;
    wr_addr_q  <= wr_addr_d;
    res_data_q <= res_data_d;
    res_scr_q  <= res_scr_d;
    res_bad_q  <= res_bad_d;
  end

  always_comb begin
    state_d          = state_q;
    ptr_d            = ptr_q;
    row_d            = row_q;
    col_d            = col_q;
    wr_pend_d        = 1'b0;
    wr_blank_d       = wr_blank_q;
    wr_addr_d        = wr_addr_q;
    res_data_d       = res_data_q;
    res_scr_d        = res_scr_q;
    res_bad_d        = res_bad_q;
    item_ready_o     = 1'b0;
    res_valid_o      = 1'b0;
    mem_req_o.we     = 1'b0;
    mem_req_o.waddr  = ptr_q;
    mem_req_o.wdata  = {tccs_pkg::RESET_COLOR, tccs_pkg::CH_BLANK};
    mem_req_o.raddr  = pos_index;

    unique case (state_q)
      tccs_pkg::ST_CLEAR: begin
        mem_req_o.we = 1'b1;
        if (ptr_q == LAST_ADDR) begin
          ptr_d   = '0;
          state_d = tccs_pkg::ST_IDLE;
        end else begin
          ptr_d = ptr_inc;
        end
      end
      tccs_pkg::ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          res_data_d = '0;
          res_scr_d  = 1'b0;
          res_bad_d  = 1'b0;
          state_d    = tccs_pkg::ST_DONE;
          unique case (item_i.action)
            tccs_pkg::ACT_PUT_CHAR: begin
              row_d           = cur_res.cur.row;
              col_d           = cur_res.cur.col;
              mem_req_o.we    = cur_res.write;
              mem_req_o.waddr = cur_index;
              mem_req_o.wdata = {color_i, item_i.char_code};
              if (cur_res.scroll) begin
                res_scr_d = 1'b1;
                ptr_d     = '0;
                state_d   = tccs_pkg::ST_COPY;
              end
            end
            tccs_pkg::ACT_PUT_ENTRY: begin
              mem_req_o.we    = pos_on_screen;
              mem_req_o.waddr = pos_index;
              mem_req_o.wdata = {item_i.entry_color, item_i.char_code};
              res_bad_d       = !pos_on_screen;
            end
            tccs_pkg::ACT_READ_CELL: begin
              res_bad_d = !pos_on_screen;
              if (pos_on_screen) begin
                state_d = tccs_pkg::ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      tccs_pkg::ST_READ: begin
        res_data_d = mem_rdata_i;
        state_d    = tccs_pkg::ST_DONE;
      end
      tccs_pkg::ST_COPY: begin
        mem_req_o.raddr = ptr_q + ROW_STRIDE;
        wr_pend_d       = 1'b1;
        wr_blank_d      = 1'b0;
        wr_addr_d       = ptr_q;
        ptr_d           = ptr_inc;
        if (ptr_q == LAST_COPY) begin
          state_d = tccs_pkg::ST_FILL;
        end
      end
      tccs_pkg::ST_FILL: begin
        wr_pend_d  = 1'b1;
        wr_blank_d = 1'b1;
        wr_addr_d  = ptr_q;
        if (ptr_q == LAST_ADDR) begin
          ptr_d   = '0;
          state_d = tccs_pkg::ST_DONE;
        end else begin
          ptr_d = ptr_inc;
        end
      end
      tccs_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = tccs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tccs_pkg::ST_IDLE;
      end
    endcase

    // A scroll writes each cell in the cycle after the read of its source is issued.
    if (wr_pend_q) begin
      mem_req_o.we    = 1'b1;
      mem_req_o.waddr = wr_addr_q;
      mem_req_o.wdata = wr_blank_q ? {color_i, tccs_pkg::CH_BLANK} : mem_rdata_i;
    end
  end

  assign res_o.cell_data    = res_data_q;
  assign res_o.cursor_row   = row_q;
  assign res_o.cursor_col   = col_q;
  assign res_o.scrolled     = res_scr_q;
  assign res_o.bad_position = res_bad_q;

  `TCCS_ASSERT_IMPL(a_cursor_on_screen, 1'b1,
    (int'(row_q) < tccs_pkg::SCREEN_ROWS) && (int'(col_q) < tccs_pkg::SCREEN_COLS),
    "Cursor left the screen.")
  `TCCS_ASSERT_IMPL(a_copy_no_overlap, wr_pend_q && (state_q == tccs_pkg::ST_COPY),
    mem_req_o.raddr != mem_req_o.waddr, "Scroll copy reads the cell it writes.")
  `TCCS_ASSERT_NEXT(a_accept_leaves_idle, item_valid_i && item_ready_o,
    state_q != tccs_pkg::ST_IDLE, "Accepted request did not start work.")
  `TCCS_ASSERT_IMPL(a_scroll_cursor, res_valid_o && res_o.scrolled,
    (res_o.cursor_row == tccs_pkg::ROW_W'(tccs_pkg::SCREEN_ROWS - 1))
      && (res_o.cursor_col == '0), "Scroll left the cursor off the last row start.")

endmodule

// ===== hw/rtl/text_console_cursor_scroll.sv =====
// Top level of the text console: stream ports, color register and result buffer.
// Depends on tccs_pkg, tccs_ctrl and tccs_cell_ram.

// After reset the block clears every cell of the cell store to grey blanks
// and takes no request meanwhile; color writes are taken at any time. A put_char,
// put_entry_at or off-screen request then goes straight to its result, a read_cell
// passes through a read state first, and a put_char that runs past the last row
// first moves the screen up, with the single write port of the cell store moving
// one cell a cycle through the 1920-cell copy and the 80-cell blank fill. One request
// is in work at a time; a finished result waits in the output register while the next request is taken.
module text_console_cursor_scroll (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,     // current_color
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // char_code, entry_color, pos_x, pos_y, zero pad
  input  logic [1:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // cell_data, cursor_row, cursor_col, scrolled,
                                      // bad_position, zero pad
);

  logic [7:0]                  color_q;
  logic                        out_valid_q;
  logic [31:0]                 out_data_q;
  tccs_pkg::item_t             item;
  tccs_pkg::result_t           res;
  logic                        res_valid;
  logic                        res_ready;
  tccs_pkg::mem_req_t          mem_req;
  logic [tccs_pkg::CELL_W-1:0] mem_rdata;

  assign cfg_ready_o = 1'b1;

  assign item.action      = tccs_pkg::action_e'(s_axis_tuser);
  assign item.char_code   = s_axis_tdata[7:0];
  assign item.entry_color = s_axis_tdata[15:8];
  assign item.pos_x       = s_axis_tdata[22:16];
  assign item.pos_y       = s_axis_tdata[27:23];

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q     <= tccs_pkg::RESET_COLOR;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        color_q <= cfg_data_i;
      end
      if (res_ready) begin
        out_valid_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= {2'b00, res.bad_position, res.scrolled, res.cursor_col,
                     res.cursor_row, res.cell_data};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  tccs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .color_i      (color_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata)
  );

  tccs_cell_ram u_cell_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== tb/text_console_cursor_scroll_checker.sv =====
// Checker for the text console: watches the color, request and result channels,
// keeps its own copy of the cell store and cursor, and compares every result.
// Depends on tccs_pkg for the screen geometry, action codes and result layout.
`timescale 1ns / 100ps

module text_console_cursor_scroll_checker
  import tccs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // char_code, entry_color, pos_x, pos_y, zero pad
  input  logic [1:0]  s_axis_tuser,   // action
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // cell_data, cursor_row, cursor_col, scrolled,
                                      // bad_position, zero pad
  output int          fail_count_o,
  output int          pending_o
);

  logic [CELL_W-1:0] cell_mem [CELL_COUNT];
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [7:0]        text_color;
  result_t           awaited_reports [$];
  result_t           seen;
  result_t           want;
  int                i;

  function automatic logic advance_line();
    int k;
    cur_col = '0;
    if (cur_row == SCREEN_ROWS - 1) begin
      for (k = 0; k < CELL_COUNT - SCREEN_COLS; k++) begin
        cell_mem[k] = cell_mem[k + SCREEN_COLS];
      end
      for (k = CELL_COUNT - SCREEN_COLS; k < CELL_COUNT; k++) begin
        cell_mem[k] = {text_color, CH_BLANK};
      end
      return 1'b1;
    end
    cur_row = cur_row + 1'b1;
    return 1'b0;
  endfunction

  function automatic result_t apply_console_request(input logic [1:0] act,
                                                    input logic [7:0] ch,
                                                    input logic [7:0] ecol,
                                                    input logic [COL_W-1:0] px,
                                                    input logic [ROW_W-1:0] py);
    result_t res;
    logic    on_screen;
    int      tab_col;
    res       = '0;
    on_screen = (px < SCREEN_COLS) && (py < SCREEN_ROWS);
    case (act)
      ACT_PUT_CHAR: begin
        if (ch == CH_NEWLINE) begin
          res.scrolled = advance_line();
        end else if (ch == CH_RETURN) begin
          cur_col = '0;
        end else if (ch == CH_TAB) begin
          tab_col = (int'(cur_col) + TAB_STEP) & ~(TAB_STEP - 1);
          if (tab_col >= SCREEN_COLS) begin
            res.scrolled = advance_line();
          end else begin
            cur_col = tab_col[COL_W-1:0];
          end
        end else begin
          cell_mem[int'(cur_row) * SCREEN_COLS + int'(cur_col)] = {text_color, ch};
          if (cur_col == SCREEN_COLS - 1) begin
            res.scrolled = advance_line();
          end else begin
            cur_col = cur_col + 1'b1;
          end
        end
      end
      ACT_PUT_ENTRY: begin
        if (on_screen) begin
          cell_mem[int'(py) * SCREEN_COLS + int'(px)] = {ecol, ch};
        end else begin
          res.bad_position = 1'b1;
        end
      end
      ACT_READ_CELL: begin
        if (on_screen) begin
          res.cell_data = cell_mem[int'(py) * SCREEN_COLS + int'(px)];
        end else begin
          res.bad_position = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.cursor_row = cur_row;
    res.cursor_col = cur_col;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (i = 0; i < CELL_COUNT; i++) begin
        cell_mem[i] = {RESET_COLOR, CH_BLANK};
      end
      cur_row      = '0;
      cur_col      = '0;
      text_color   = RESET_COLOR;
      awaited_reports.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        text_color = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_reports.push_back(apply_console_request(s_axis_tuser, s_axis_tdata[7:0],
                                                        s_axis_tdata[15:8],
                                                        s_axis_tdata[22:16],
                                                        s_axis_tdata[27:23]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.cell_data    = m_axis_tdata[15:0];
        seen.cursor_row   = m_axis_tdata[20:16];
        seen.cursor_col   = m_axis_tdata[27:21];
        seen.scrolled     = m_axis_tdata[28];
        seen.bad_position = m_axis_tdata[29];
        if (awaited_reports.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("%0t: result with no request pending: data %h", $realtime,
                     m_axis_tdata);
          end
        end else begin
          want = awaited_reports.pop_front();
          if (seen.cell_data !== want.cell_data || seen.cursor_row !== want.cursor_row ||
              seen.cursor_col !== want.cursor_col || seen.scrolled !== want.scrolled ||
              seen.bad_position !== want.bad_position) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: result mismatch: expected cell %h row %0d col %0d scroll %b bad %b",
                       $realtime, want.cell_data, want.cursor_row, want.cursor_col,
                       want.scrolled, want.bad_position);
              $display("%0t:                    got cell %h row %0d col %0d scroll %b bad %b",
                       $realtime, seen.cell_data, seen.cursor_row, seen.cursor_col,
                       seen.scrolled, seen.bad_position);
            end
          end
        end
      end
      pending_o = awaited_reports.size();
    end
  end

endmodule

// ===== tb/text_console_cursor_scroll_tb.sv =====
// Testbench top for the text console: clock, reset, request and color stimulus,
// result back-pressure and the verdict. Depends on tccs_pkg, the block under test
// and text_console_cursor_scroll_checker, which predicts and compares.
`timescale 1ns / 100ps

module text_console_cursor_scroll_tb;
  import tccs_pkg::*;

  localparam logic [1:0] ACT_IGNORED = 2'd3;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  int          fail_count;
  int          pending;
  int          burst_left;
  bit          hold_off_req;

  text_console_cursor_scroll dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  text_console_cursor_scroll_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  task automatic send_request(input logic [1:0] act, input logic [7:0] ch,
                              input logic [7:0] ecol, input logic [COL_W-1:0] px,
                              input logic [ROW_W-1:0] py);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
                                               : $urandom_range(1, 16);
      gap = $urandom_range(0, 10);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {4'b0, py, px, ecol, ch};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_color(input logic [7:0] color);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= color;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : receiver
    stall_mode_e mode;
    int          span;
    int          k;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_off_req) begin
        for (k = 0; k < 400; k++) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b0;
        end
        hold_off_req = 1'b0;
      end
      mode = stall_mode_e'($urandom_range(0, 3));
      span = $urandom_range(8, 90);
      for (k = 0; k < span; k++) begin
        @(negedge clk_i);
        case (mode)
          STALL_NONE:  m_axis_tready <= 1'b1;
          STALL_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
          STALL_HEAVY: m_axis_tready <= ($urandom_range(0, 2) == 0);
          default:     m_axis_tready <= ((k % 4) != 3);
        endcase
      end
    end
  end

  initial begin : watchdog
    #150_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]       color_plan [6];
    int               newline_plan [6];
    logic [1:0]       act;
    logic [7:0]       ch;
    logic [7:0]       ecol;
    logic [COL_W-1:0] px;
    logic [ROW_W-1:0] py;
    int               phase;
    int               n;
    int               sel;
    int               pick;

    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    burst_left    = 0;
    hold_off_req  = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_color(8'h1E);

    // Directed part: reset contents, control characters, corners and off-screen positions.
    send_request(ACT_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd0);
    send_request(ACT_READ_CELL, 8'hFF, 8'hFF, 7'd79, 5'd24);
    send_request(ACT_PUT_CHAR, 8'h41, 8'h00, 7'd0, 5'd0);
    send_request(ACT_PUT_CHAR, CH_TAB, 8'h00, 7'd0, 5'd0);
    send_request(ACT_PUT_CHAR, CH_RETURN, 8'h00, 7'd0, 5'd0);
    send_request(ACT_PUT_CHAR, CH_NEWLINE, 8'h00, 7'd0, 5'd0);
    send_request(ACT_PUT_ENTRY, 8'hFF, 8'hFF, 7'd79, 5'd24);
    send_request(ACT_READ_CELL, 8'h00, 8'h00, 7'd79, 5'd24);
    send_request(ACT_PUT_ENTRY, 8'h55, 8'hAA, 7'd80, 5'd0);
    send_request(ACT_PUT_ENTRY, 8'h55, 8'hAA, 7'd0, 5'd25);
    send_request(ACT_PUT_ENTRY, 8'hFF, 8'hFF, 7'd127, 5'd31);
    send_request(ACT_READ_CELL, 8'h00, 8'h00, 7'd80, 5'd3);
    send_request(ACT_READ_CELL, 8'h00, 8'h00, 7'd5, 5'd31);
    send_request(ACT_IGNORED, 8'hFF, 8'hFF, 7'd127, 5'd31);
    send_request(ACT_IGNORED, 8'h00, 8'h00, 7'd0, 5'd0);
    send_request(ACT_PUT_CHAR, 8'h00, 8'hFF, 7'd127, 5'd31);
    send_request(ACT_PUT_CHAR, 8'hFF, 8'h00, 7'd0, 5'd0);
    send_request(ACT_PUT_ENTRY, 8'h00, 8'h00, 7'd0, 5'd0);
    send_request(ACT_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd0);
    send_request(ACT_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd1);
    send_request(ACT_READ_CELL, 8'h00, 8'h00, 7'd1, 5'd1);

    color_plan[0]   = 8'h00;
    color_plan[1]   = 8'hFF;
    color_plan[2]   = 8'($urandom_range(0, 255));
    color_plan[3]   = 8'($urandom_range(0, 255));
    color_plan[4]   = RESET_COLOR;
    color_plan[5]   = 8'($urandom_range(0, 255));
    newline_plan[0] = 2;
    newline_plan[1] = 25;
    newline_plan[2] = 5;
    newline_plan[3] = 40;
    newline_plan[4] = 3;
    newline_plan[5] = 15;

    for (phase = 0; phase < 6; phase++) begin
      write_color(color_plan[phase]);
      if (phase == 1) begin
        hold_off_req = 1'b1;
      end
      for (n = 0; n < 190; n++) begin
        ch   = 8'($urandom_range(0, 255));
        ecol = 8'($urandom_range(0, 255));
        px   = COL_W'($urandom_range(0, 127));
        py   = ROW_W'($urandom_range(0, 31));
        if ($urandom_range(0, 99) < 85) begin
          px = COL_W'($urandom_range(0, SCREEN_COLS - 1));
          py = ROW_W'($urandom_range(0, SCREEN_ROWS - 1));
        end
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          act  = ACT_PUT_CHAR;
          pick = $urandom_range(0, 99);
          if (pick < newline_plan[phase]) begin
            ch = CH_NEWLINE;
          end else if (pick < newline_plan[phase] + 10) begin
            ch = CH_TAB;
          end else if (pick < newline_plan[phase] + 14) begin
            ch = CH_RETURN;
          end
        end else if (sel < 65) begin
          act = ACT_PUT_ENTRY;
        end else if (sel < 95) begin
          act = ACT_READ_CELL;
        end else begin
          act = ACT_IGNORED;
        end
        send_request(act, ch, ecol, px, py);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
